>>> rtl/core/qur_pkg.sv
`timescale 1ns / 1ps

package qur_pkg;

  localparam int unsigned QUR_LANES = 4;
  localparam int unsigned QUR_SHOWN = 4;
  localparam int unsigned QUR_ADDR_W = 5;
  localparam int unsigned QUR_IN_W = 8;
  localparam int unsigned QUR_OUT_W = 80;

  typedef enum logic [2:0] {
    REG_TRIGGER_TICKS = 3'd0,
    REG_ECHO_TIMEOUT  = 3'd1,
    REG_GAP_TICKS     = 3'd2,
    REG_HALF_SPEED    = 3'd3,
    REG_MAX_DISTANCE  = 3'd4
  } reg_idx_t;

  typedef enum logic [2:0] {
    PH_IDLE = 3'd0,
    PH_TRIG = 3'd1,
    PH_WAIT = 3'd2,
    PH_HIGH = 3'd3,
    PH_DONE = 3'd4
  } lane_phase_t;

  typedef struct packed {
    logic [7:0]  trigger_ticks;
    logic [15:0] echo_timeout_ticks;
    logic [15:0] gap_ticks;
    logic [15:0] half_speed_q16;
    logic [15:0] max_distance_mm;
  } cfg_t;

  typedef struct packed {
    logic        idle;
    logic        done_nxt;
    logic        trig_nxt;
    logic        valid_nxt;
    logic [15:0] dist_nxt;
  } lane_stat_t;

  typedef struct packed {
    logic        start;
    logic        advance;
    logic        clear;
  } lane_ctl_t;

endpackage

>>> rtl/core/qur_cfg_regs.sv
`timescale 1ns / 1ps

module qur_cfg_regs
  import qur_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_psel,
  input  logic                  cfg_penable,
  input  logic                  cfg_pwrite,
  input  logic [QUR_ADDR_W-1:0] cfg_paddr,
  input  logic [31:0]           cfg_pwdata,
  output logic [31:0]           cfg_prdata,
  output logic                  cfg_pready,
  output cfg_t                  cfg
);

  cfg_t     cfg_r;
  cfg_t     cfg_nxt;
  reg_idx_t idx;
  logic     wr_en;

  assign idx        = reg_idx_t'(cfg_paddr[QUR_ADDR_W-1:2]);
  assign wr_en      = cfg_psel && cfg_penable && cfg_pwrite;
  assign cfg_pready = 1'b1;
  assign cfg        = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      case (idx)
        REG_TRIGGER_TICKS: cfg_nxt.trigger_ticks      = cfg_pwdata[7:0];
        REG_ECHO_TIMEOUT:  cfg_nxt.echo_timeout_ticks = cfg_pwdata[15:0];
        REG_GAP_TICKS:     cfg_nxt.gap_ticks          = cfg_pwdata[15:0];
        REG_HALF_SPEED:    cfg_nxt.half_speed_q16     = cfg_pwdata[15:0];
        REG_MAX_DISTANCE:  cfg_nxt.max_distance_mm    = cfg_pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_TRIGGER_TICKS: cfg_prdata = {24'd0, cfg_r.trigger_ticks};
      REG_ECHO_TIMEOUT:  cfg_prdata = {16'd0, cfg_r.echo_timeout_ticks};
      REG_GAP_TICKS:     cfg_prdata = {16'd0, cfg_r.gap_ticks};
      REG_HALF_SPEED:    cfg_prdata = {16'd0, cfg_r.half_speed_q16};
      REG_MAX_DISTANCE:  cfg_prdata = {16'd0, cfg_r.max_distance_mm};
      default:           cfg_prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.trigger_ticks      <= 8'd10;
      cfg_r.echo_timeout_ticks <= 16'd15000;
      cfg_r.gap_ticks          <= 16'd50000;
      cfg_r.half_speed_q16     <= 16'd11239;
      cfg_r.max_distance_mm    <= 16'd4000;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

>>> rtl/core/qur_lane.sv
`timescale 1ns / 1ps

module qur_lane
  import qur_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  cfg_t       cfg,
  input  lane_ctl_t  ctl,
  input  logic       echo,
  output lane_stat_t stat
);

  lane_phase_t phase_r, phase_nxt;
  logic [15:0] cnt_r, cnt_nxt;
  logic [15:0] dist_r, dist_nxt;
  logic        valid_r, valid_nxt;

  logic        fin;
  logic        got;
  logic [15:0] fin_cnt;
  logic [16:0] cnt_inc;
  logic [15:0] cnt_high;
  logic [31:0] prod;
  logic [32:0] rnd;
  logic [15:0] mm;
  logic        ok;

  assign cnt_inc  = {1'b0, cnt_r} + 17'd1;
  assign cnt_high = (cnt_r < cfg.echo_timeout_ticks) ? cnt_inc[15:0] : cnt_r;

  always_comb begin
    phase_nxt = phase_r;
    cnt_nxt   = cnt_r;
    fin       = 1'b0;
    got       = 1'b0;
    fin_cnt   = cnt_r;
    if (ctl.start) begin
      phase_nxt = PH_TRIG;
      cnt_nxt   = {8'd0, cfg.trigger_ticks};
    end else if (ctl.advance) begin
      case (phase_r)
        PH_IDLE: ;
        PH_TRIG: begin
          if (cnt_r <= 16'd1) begin
            phase_nxt = PH_WAIT;
            cnt_nxt   = 16'd0;
          end else begin
            cnt_nxt = cnt_r - 16'd1;
          end
        end
        PH_WAIT: begin
          if (echo) begin
            phase_nxt = PH_HIGH;
            cnt_nxt   = 16'd1;
            if (cfg.echo_timeout_ticks <= 16'd1) begin
              fin     = 1'b1;
              got     = 1'b1;
              fin_cnt = 16'd1;
            end
          end else begin
            cnt_nxt = cnt_inc[15:0];
            if (cnt_inc >= {1'b0, cfg.echo_timeout_ticks}) begin
              fin = 1'b1;
            end
          end
        end
        PH_HIGH: begin
          if (!echo) begin
            fin = 1'b1;
            got = 1'b1;
          end else begin
            cnt_nxt = cnt_high;
            if (cnt_high >= cfg.echo_timeout_ticks) begin
              fin     = 1'b1;
              got     = 1'b1;
              fin_cnt = cnt_high;
            end
          end
        end
        PH_DONE: ;
        default: phase_nxt = PH_DONE;
      endcase
    end
    if (fin) begin
      phase_nxt = PH_DONE;
    end
  end

  assign prod = fin_cnt * cfg.half_speed_q16;
  assign rnd  = {1'b0, prod} + 33'd32768;
  assign mm   = rnd[31:16];
  assign ok   = got && (mm <= cfg.max_distance_mm);

  always_comb begin
    dist_nxt  = dist_r;
    valid_nxt = valid_r;
    if (fin) begin
      dist_nxt  = ok ? mm : 16'd0;
      valid_nxt = ok;
    end
  end

  assign stat.idle      = (phase_r == PH_IDLE);
  assign stat.done_nxt  = (phase_nxt == PH_DONE);
  assign stat.trig_nxt  = (phase_nxt == PH_TRIG);
  assign stat.valid_nxt = valid_nxt;
  assign stat.dist_nxt  = dist_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      cnt_r   <= 16'd0;
      dist_r  <= 16'd0;
      valid_r <= 1'b0;
    end else begin
      dist_r  <= dist_nxt;
      valid_r <= valid_nxt;
      if (ctl.clear) begin
        phase_r <= PH_IDLE;
        cnt_r   <= 16'd0;
      end else begin
        phase_r <= phase_nxt;
        cnt_r   <= cnt_nxt;
      end
    end
  end

endmodule

>>> rtl/core/quad_ultrasonic_ranger_unit.sv
`timescale 1ns / 1ps
// Each accepted tick's result is registered into the output buffer; four ranging
// lanes step in parallel each tick. Throughput: one tick per cycle while
// in_tready is high. A two-entry output buffer keeps in_tready high while one
// result waits. Reset (rst_n low, synchronous): lanes idle, distances 0, valid
// bits 0, gap counter 0, registers at their defaults, output buffer empty.

module quad_ultrasonic_ranger_unit
  import qur_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // [3:0] echo_lines, [4] run_enable, [7:5] zero
  input  logic [QUR_IN_W-1:0]   in_tdata,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // [3:0] trigger_lines, [19:4] dist_front, [35:20] dist_left, [51:36] dist_back,
  // [67:52] dist_right, [71:68] valid_lines, [72] set_done, [73] all_valid,
  // [79:74] zero
  output logic [QUR_OUT_W-1:0]  out_tdata,
  input  logic                  cfg_psel,
  input  logic                  cfg_penable,
  input  logic                  cfg_pwrite,
  input  logic [QUR_ADDR_W-1:0] cfg_paddr,
  input  logic [31:0]           cfg_pwdata,
  output logic [31:0]           cfg_prdata,
  output logic                  cfg_pready
);

  cfg_t       cfg;
  lane_ctl_t  ctl;
  lane_stat_t stat [QUR_LANES];

  logic [QUR_LANES-1:0] idle_v, done_v, trig_v, valid_v;
  logic [15:0]          dist_v [QUR_LANES];
  logic [3:0]           echo_lines;
  logic                 run_enable;
  logic                 accept;
  logic                 all_idle;
  logic                 all_done;

  logic [15:0] gap_r, gap_nxt;

  logic [3:0]           trig_o, valid_o;
  logic [15:0]          dist_o [QUR_SHOWN];
  logic [QUR_OUT_W-1:0] result;

  logic                 out_valid_r, skid_valid_r;
  logic [QUR_OUT_W-1:0] out_data_r, skid_data_r;
  logic                 pop;

  qur_cfg_regs u_cfg (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .cfg         (cfg)
  );

  assign echo_lines = in_tdata[3:0];
  assign run_enable = in_tdata[4];
  assign accept     = in_tvalid && in_tready;

  for (genvar i = 0; i < QUR_LANES; i++) begin : g_lane
    logic echo_i;
    if (i < QUR_SHOWN) begin : g_pin
      assign echo_i = echo_lines[i];
    end else begin : g_nopin
      assign echo_i = 1'b0;
    end

    qur_lane u_lane (
      .clk   (clk),
      .rst_n (rst_n),
      .cfg   (cfg),
      .ctl   (ctl),
      .echo  (echo_i),
      .stat  (stat[i])
    );

    assign idle_v[i]  = stat[i].idle;
    assign done_v[i]  = stat[i].done_nxt;
    assign trig_v[i]  = stat[i].trig_nxt;
    assign valid_v[i] = stat[i].valid_nxt;
    assign dist_v[i]  = stat[i].dist_nxt;
  end

  assign all_idle = &idle_v;
  assign all_done = !all_idle && (&done_v);

  assign ctl.start   = accept && all_idle && (gap_r == 16'd0) && run_enable;
  assign ctl.advance = accept && !all_idle;
  assign ctl.clear   = accept && all_done;

  always_comb begin
    gap_nxt = gap_r;
    if (accept) begin
      if (all_idle && (gap_r != 16'd0)) begin
        gap_nxt = gap_r - 16'd1;
      end else if (all_done) begin
        gap_nxt = cfg.gap_ticks;
      end
    end
  end

  // merge lane results into one transaction
  for (genvar k = 0; k < QUR_SHOWN; k++) begin : g_show
    if (k < QUR_LANES) begin : g_on
      assign trig_o[k]  = trig_v[k] && !all_done;
      assign valid_o[k] = valid_v[k];
      assign dist_o[k]  = dist_v[k];
    end else begin : g_off
      assign trig_o[k]  = 1'b0;
      assign valid_o[k] = 1'b0;
      assign dist_o[k]  = 16'd0;
    end
  end

  assign result = {6'd0, (&valid_v), all_done, valid_o,
                   dist_o[3], dist_o[2], dist_o[1], dist_o[0], trig_o};

  assign in_tready  = !skid_valid_r;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign pop        = out_valid_r && out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gap_r        <= 16'd0;
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      gap_r <= gap_nxt;
      if (!out_valid_r) begin
        out_valid_r <= accept;
      end else if (pop) begin
        if (skid_valid_r) begin
          skid_valid_r <= accept;
        end else begin
          out_valid_r <= accept;
        end
      end else if (accept) begin
        skid_valid_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid_r || (pop && !skid_valid_r)) begin
      out_data_r <= result;
    end else if (pop) begin
      out_data_r <= skid_data_r;
    end
    if (accept && out_valid_r && (skid_valid_r || !pop)) begin
      skid_data_r <= result;
    end
  end

  a_skid_needs_head: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid entry held without head entry");

  a_lanes_in_step: assert property (@(posedge clk) disable iff (!rst_n)
    (idle_v == '0) || (idle_v == '1))
    else $error("lanes out of step");

  a_gap_clear_in_set: assert property (@(posedge clk) disable iff (!rst_n)
    !all_idle |-> (gap_r == 16'd0))
    else $error("gap counter running during a set");

  a_gap_counts_down: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && all_idle && (gap_r != 16'd0)) |=> (gap_r == $past(gap_r) - 16'd1))
    else $error("gap counter did not advance");

endmodule
